### src/bc_pkg.sv
package bc_pkg;

  localparam int RAW_W    = 24;
  localparam int NUM_W    = 35;   // pre-shifted dividend for the constant divider
  localparam int DIVR_W   = 8;    // odd divisor part of the scale factor
  localparam int QUO_W    = 31;   // quotient magnitude, below 2^30
  localparam int SCL_W    = 32;   // scaled raw value, signed Q7.24
  localparam int CFG_W    = 48;
  localparam int CFG_IDX_W = 3;
  localparam int OS_W     = 3;
  localparam int RCP_W    = 44;   // reciprocal of the odd divisor, 2^43 scale
  localparam int RCP_SHIFT = 43;
  localparam int DIV_STAGES = 3;  // pipeline depth of the reciprocal divider

  localparam logic [63:0] RCP_ONE = 64'd1 << RCP_SHIFT;

  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_MID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_OS   = 3'd4;

  localparam logic [OS_W-1:0] TEMP_OS_RESET  = 3'd3;
  localparam logic [OS_W-1:0] PRESS_OS_RESET = 3'd6;

  // One raw value prepared for division: scale factor k = div * 2^s.
  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [DIVR_W-1:0] divr;
    logic              neg;
  } bc_lane_t;

  typedef struct packed {
    bc_lane_t temp;
    bc_lane_t press;
  } bc_item_t;

  // Odd part of the scale factor for each oversampling code.
  function automatic logic [DIVR_W-1:0] scale_divisor(input logic [OS_W-1:0] code);
    logic [DIVR_W-1:0] d;
    case (code)
      3'd0:    d = 8'd1;
      3'd1:    d = 8'd3;
      3'd2:    d = 8'd7;
      3'd3:    d = 8'd15;
      3'd4:    d = 8'd31;
      3'd5:    d = 8'd63;
      3'd6:    d = 8'd127;
      default: d = 8'd255;
    endcase
    return d;
  endfunction

  // Rounded-up reciprocal 2^43 / d; exact floor for dividends below 2^35.
  function automatic logic [RCP_W-1:0] scale_recip(input logic [DIVR_W-1:0] d);
    logic [RCP_W-1:0] m;
    case (d)
      8'd1:    m = RCP_W'(RCP_ONE);
      8'd3:    m = RCP_W'((RCP_ONE + 64'd2) / 64'd3);
      8'd7:    m = RCP_W'((RCP_ONE + 64'd6) / 64'd7);
      8'd15:   m = RCP_W'((RCP_ONE + 64'd14) / 64'd15);
      8'd31:   m = RCP_W'((RCP_ONE + 64'd30) / 64'd31);
      8'd63:   m = RCP_W'((RCP_ONE + 64'd62) / 64'd63);
      8'd127:  m = RCP_W'((RCP_ONE + 64'd126) / 64'd127);
      default: m = RCP_W'((RCP_ONE + 64'd254) / 64'd255);
    endcase
    return m;
  endfunction

  // Magnitude times 2^24 / 2^s plus half the odd divisor, floored.
  function automatic bc_lane_t prep_lane(input logic [RAW_W-1:0] raw,
                                         input logic [OS_W-1:0] code);
    bc_lane_t          l;
    logic [RAW_W-1:0]  mag;
    logic [DIVR_W-1:0] d;
    logic [NUM_W-1:0]  sh;
    mag = raw[RAW_W-1] ? (~raw + 24'd1) : raw;
    d   = scale_divisor(code);
    sh  = code[2] ? {mag, 11'b0} : {6'b0, mag, 5'b0};
    l.num  = sh + NUM_W'(d >> 1);
    l.divr = d;
    l.neg  = raw[RAW_W-1];
    return l;
  endfunction

endpackage

### src/bc_front.sv
module bc_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [47:0]             in_data,
  input  logic [bc_pkg::OS_W-1:0] temp_os,
  input  logic [bc_pkg::OS_W-1:0] press_os,
  input  logic                    q_full,
  output logic                    q_push,
  output bc_pkg::bc_item_t        q_item
);
  import bc_pkg::*;

  logic busy;

  // hold off input while busy is set after reset, so the queue can come up
  always_ff @(posedge clk) begin
    if (rst) busy <= 1'b1;
    else     busy <= 1'b0;
  end

  assign in_ready     = !q_full && !busy;
  assign q_push       = in_valid && in_ready;
  assign q_item.temp  = prep_lane(in_data[23:0], temp_os);
  assign q_item.press = prep_lane(in_data[47:24], press_os);

endmodule

### src/bc_fifo.sv
module bc_fifo #(
  parameter int W     = 88,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem [DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (do_pop)  rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### src/bc_div.sv
module bc_div (
  input  logic                      clk,
  input  logic                      en,
  input  bc_pkg::bc_lane_t          lane,
  output logic signed [bc_pkg::SCL_W-1:0] scaled
);
  import bc_pkg::*;

  logic [RCP_W-1:0] rcp;
  logic [39:0]      pp_ll, pp_lh;
  logic [38:0]      pp_hl, pp_hh;
  logic [62:0]      sum_a;
  logic [61:0]      sum_b;
  logic [QUO_W-1:0] quo;
  logic             neg1, neg2, neg3;

  // quotient by multiplication with the rounded-up reciprocal
  assign rcp = scale_recip(lane.divr);

  always_ff @(posedge clk) begin
    if (en) begin
      // partial products of the dividend and reciprocal halves
      pp_ll <= lane.num[17:0]  * rcp[21:0];
      pp_lh <= lane.num[17:0]  * rcp[43:22];
      pp_hl <= lane.num[34:18] * rcp[21:0];
      pp_hh <= lane.num[34:18] * rcp[43:22];
      neg1  <= lane.neg;
      // merge pairs
      sum_a <= 63'(pp_ll) + (63'(pp_lh) << 22);
      sum_b <= 62'(pp_hl) + (62'(pp_hh) << 22);
      neg2  <= neg1;
      // final sum, drop the fraction
      quo   <= QUO_W'((80'(sum_a) + (80'(sum_b) << 18)) >> RCP_SHIFT);
      neg3  <= neg2;
    end
  end

  logic signed [SCL_W-1:0] mag;
  assign mag    = $signed({1'b0, quo});
  assign scaled = neg3 ? -mag : mag;

endmodule

### src/bc_back.sv
module bc_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  input  bc_pkg::bc_item_t         q_item,
  output logic                     q_pop,
  input  logic [bc_pkg::CFG_W-1:0] calib_low,
  input  logic [bc_pkg::CFG_W-1:0] calib_mid,
  input  logic [bc_pkg::CFG_W-1:0] calib_high,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [55:0]              out_data
);
  import bc_pkg::*;

  localparam int STEPS = DIV_STAGES;

  logic en;
  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  // coefficients; the user must keep them static while items are in flight, the block does not enforce it
  logic signed [11:0] c0, c1;
  logic signed [19:0] c00, c10;
  logic signed [15:0] c01, c11, c20, c21, c30;
  assign c0  = $signed(calib_low[47:36]);
  assign c1  = $signed(calib_low[35:24]);
  assign c00 = $signed(calib_low[23:4]);
  assign c10 = $signed({calib_low[3:0], calib_mid[47:32]});
  assign c01 = $signed(calib_mid[31:16]);
  assign c11 = $signed(calib_mid[15:0]);
  assign c20 = $signed(calib_high[47:32]);
  assign c21 = $signed(calib_high[31:16]);
  assign c30 = $signed(calib_high[15:0]);

  logic signed [SCL_W-1:0] ts0, ps0;
  bc_div u_div_t (.clk(clk), .en(en), .lane(q_item.temp),  .scaled(ts0));
  bc_div u_div_p (.clk(clk), .en(en), .lane(q_item.press), .scaled(ps0));

  logic [STEPS-1:0] vdiv;
  logic [8:1]       vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vdiv      <= '0;
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vdiv      <= {vdiv[STEPS-2:0], !q_empty};
      vld       <= {vld[7:1], vdiv[STEPS-1]};
      out_valid <= vld[8];
    end
  end

  logic signed [31:0] ts1, ps1;
  logic signed [47:0] m_psc30, m_psc21, m_tsc01;
  logic signed [63:0] m_tsps;
  logic signed [43:0] m_tsc1;
  logic signed [31:0] ps2;
  logic signed [31:0] a3, d3, e3, ps3;
  logic signed [35:0] tp3;
  logic signed [23:0] t3;
  logic signed [63:0] m_psa;
  logic signed [50:0] tdh;
  logic signed [49:0] tdl;
  logic signed [31:0] ps4, e4;
  logic signed [23:0] t4;
  logic signed [34:0] bb5;
  logic signed [39:0] td5;
  logic signed [31:0] ps5, e5;
  logic signed [23:0] t5;
  logic signed [49:0] pbh, pbl;
  logic signed [39:0] td6;
  logic signed [31:0] e6;
  logic signed [23:0] t6;
  logic signed [39:0] f7, td7;
  logic signed [31:0] e7;
  logic signed [23:0] t7;
  logic signed [41:0] p8;
  logic signed [23:0] t8;
  logic signed [31:0] pres_q;
  logic signed [23:0] temp_q;

  logic signed [47:0] a_sum, d_sum;
  logic signed [63:0] tp_sum, m_sum, td_sum, f_sum;
  logic signed [47:0] e_sum;
  logic signed [43:0] t_sum;
  logic signed [41:0] p_rnd;

  assign a_sum  = (48'(c20) <<< 8) + ((m_psc30 + 48'sd32768) >>> 16);
  assign d_sum  = (48'(c11) <<< 8) + ((m_psc21 + 48'sd32768) >>> 16);
  assign e_sum  = (m_tsc01 + 48'sd32768) >>> 16;
  assign tp_sum = (m_tsps + 64'sd8388608) >>> 24;
  assign t_sum  = (44'(c0) <<< 7) + ((m_tsc1 + 44'sd32768) >>> 16);
  assign m_sum  = (64'(c10) <<< 8) + ((m_psa + 64'sd8388608) >>> 24);
  assign td_sum = ((64'(tdh) <<< 17) + 64'(tdl) + 64'sd8388608) >>> 24;
  assign f_sum  = ((64'(pbh) <<< 17) + 64'(pbl) + 64'sd8388608) >>> 24;
  assign p_rnd  = (p8 + 42'sd2) >>> 2;

  always_ff @(posedge clk) begin
    if (en) begin
      // scaled raws
      ts1 <= ts0;
      ps1 <= ps0;
      // first products
      m_psc30 <= ps1 * c30;
      m_psc21 <= ps1 * c21;
      m_tsc01 <= ts1 * c01;
      m_tsps  <= ts1 * ps1;
      m_tsc1  <= ts1 * c1;
      ps2     <= ps1;
      // round, add offsets, finish temperature
      a3  <= a_sum[31:0];
      d3  <= d_sum[31:0];
      e3  <= e_sum[31:0];
      tp3 <= tp_sum[35:0];
      if (t_sum > 44'sd8388607)        t3 <= 24'sh7FFFFF;
      else if (t_sum < -44'sd8388608)  t3 <= 24'sh800000;
      else                             t3 <= t_sum[23:0];
      ps3 <= ps2;
      // second products, tp*d split in two
      m_psa <= ps3 * a3;
      tdh   <= d3 * $signed(tp3[35:17]);
      tdl   <= d3 * $signed({1'b0, tp3[16:0]});
      ps4   <= ps3;
      e4    <= e3;
      t4    <= t3;
      // b term and merged cross term
      bb5 <= m_sum[34:0];
      td5 <= td_sum[39:0];
      ps5 <= ps4;
      e5  <= e4;
      t5  <= t4;
      // Ps*b split in two
      pbh <= ps5 * $signed(bb5[34:17]);
      pbl <= ps5 * $signed({1'b0, bb5[16:0]});
      td6 <= td5;
      e6  <= e5;
      t6  <= t5;
      // merge and round
      f7  <= f_sum[39:0];
      td7 <= td6;
      e7  <= e6;
      t7  <= t6;
      // pressure sum in Q8
      p8 <= (42'(c00) <<< 8) + 42'(f7) + 42'(e7) + 42'(td7);
      t8 <= t7;
      // output register
      if (p_rnd > 42'sd2147483647)       pres_q <= 32'sh7FFFFFFF;
      else if (p_rnd < -42'sd2147483648) pres_q <= 32'sh80000000;
      else                               pres_q <= p_rnd[31:0];
      temp_q <= t8;
    end
  end

  assign out_data = {temp_q, pres_q};

endmodule

### src/barometer_compensation.sv
// Barometer compensation: raw temperature/pressure pair in, compensated pair out.
// Path to m_tvalid: the queue, 3 reciprocal divider stages, 8 polynomial stages,
// the output register. Throughput: one item per cycle unless the output stalls; a
// stalled output holds the back pipeline, then fills the queue and drops s_tready.
// Reset (synchronous, active high): calibration cleared, oversampling codes 3 and 6,
// queue and pipeline emptied; input is accepted once the front's busy flag clears.
module barometer_compensation #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // input item
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // raw_temperature [23:0], raw_pressure [47:24]
  // result item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // pressure_out [31:0], temperature_out [55:32]
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import bc_pkg::*;

  logic [CFG_W-1:0] calib_low, calib_mid, calib_high;
  logic [OS_W-1:0]  temp_os, press_os;

  // register file: unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_low  <= '0;
      calib_mid  <= '0;
      calib_high <= '0;
      temp_os    <= TEMP_OS_RESET;
      press_os   <= PRESS_OS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CALIB_LOW:  calib_low  <= cfg_data;
        CFG_CALIB_MID:  calib_mid  <= cfg_data;
        CFG_CALIB_HIGH: calib_high <= cfg_data;
        CFG_TEMP_OS:    temp_os    <= cfg_data[OS_W-1:0];
        CFG_PRESS_OS:   press_os   <= cfg_data[OS_W-1:0];
        default: ;
      endcase
    end
  end

  logic     q_full, q_empty, q_push, q_pop;
  bc_item_t wr_item, rd_item;

  // front: accept the item and turn each raw value into dividend and divisor
  bc_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
    .temp_os(temp_os), .press_os(press_os),
    .q_full(q_full), .q_push(q_push), .q_item(wr_item)
  );

  // queue parts the input handshake from output back-pressure
  bc_fifo #(.W($bits(bc_item_t)), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk(clk), .rst(rst),
    .push(q_push), .wdata(wr_item), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(rd_item)
  );

  // back: divide, evaluate the polynomials, saturate, hold in the output register
  bc_back u_back (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .q_item(rd_item), .q_pop(q_pop),
    .calib_low(calib_low), .calib_mid(calib_mid), .calib_high(calib_high),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata)
  );

endmodule

### verif/tb_barometer_compensation.sv
`timescale 1ns / 100ps

module tb_barometer_compensation;
  import bc_pkg::*;

  // Allow generous slack after the last result.
  localparam int DRAIN_CYCLES = 120;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // raw_temperature [23:0], raw_pressure [47:24]
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;   // pressure_out [31:0], temperature_out [55:32]
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_data;

  // Laid out as on m_tdata: temperature in the upper bits.
  typedef struct packed {
    logic signed [23:0] temperature;
    logic signed [31:0] pressure;
  } reading_t;

  // Local copy of the configuration registers.
  logic [47:0] calib_low, calib_mid, calib_high;
  logic [2:0]  temp_os, press_os;

  reading_t    readings_due[$];
  int          errors;
  int          items_sent;
  int          results_seen;
  bit          hold_off_req;   // ask the receiver for a long stall
  bit          rx_enable;

  barometer_compensation i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #20ms;
    $display("Timeout at %0t", $time);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Compensation predictor
  // ---------------------------------------------------------------------------

  function automatic longint os_scale(input logic [2:0] code);
    case (code)
      3'd0:    return 524288;
      3'd1:    return 1572864;
      3'd2:    return 3670016;
      3'd3:    return 7864320;
      3'd4:    return 253952;
      3'd5:    return 516096;
      3'd6:    return 1040384;
      default: return 2088960;
    endcase
  endfunction

  // Round to nearest by a right shift, ties toward plus infinity.
  function automatic longint round_shift(input longint x, input int n);
    longint v;
    v = x + (64'sd1 <<< (n - 1));
    return v >>> n;
  endfunction

  // Raw count divided by its scale factor as Q7.24, ties away from zero.
  function automatic longint scale_raw(input logic [23:0] raw, input logic [2:0] code);
    longint r, k, q;
    longint unsigned mag;
    r   = longint'($signed(raw));
    k   = os_scale(code);
    mag = longint'(r < 0 ? -r : r) << 24;
    q   = longint'((mag + longint'(k / 2)) / longint'(k));
    return r < 0 ? -q : q;
  endfunction

  function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic reading_t compensate(input logic [23:0] raw_t, input logic [23:0] raw_p);
    logic [7:0] cb [18];
    logic [47:0] regs [3];
    longint c0, c1, c00, c10, c01, c11, c20, c21, c30;
    longint ts, ps, t, a, bb, tp, d, p8, p;
    reading_t r;
    regs[0] = calib_low;
    regs[1] = calib_mid;
    regs[2] = calib_high;
    for (int i = 0; i < 18; i++) begin
      cb[i] = regs[i / 6][(5 - i % 6) * 8 +: 8];
    end
    c0  = longint'($signed({cb[0], cb[1][7:4]}));
    c1  = longint'($signed({cb[1][3:0], cb[2]}));
    c00 = longint'($signed({cb[3], cb[4], cb[5][7:4]}));
    c10 = longint'($signed({cb[5][3:0], cb[6], cb[7]}));
    c01 = longint'($signed({cb[8], cb[9]}));
    c11 = longint'($signed({cb[10], cb[11]}));
    c20 = longint'($signed({cb[12], cb[13]}));
    c21 = longint'($signed({cb[14], cb[15]}));
    c30 = longint'($signed({cb[16], cb[17]}));
    ts = scale_raw(raw_t, temp_os);
    ps = scale_raw(raw_p, press_os);
    t  = clamp_to(c0 * 128 + round_shift(ts * c1, 16), -8388608, 8388607);
    a  = c20 * 256 + round_shift(ps * c30, 16);
    bb = c10 * 256 + round_shift(ps * a, 24);
    tp = round_shift(ts * ps, 24);
    d  = c11 * 256 + round_shift(ps * c21, 16);
    p8 = c00 * 256 + round_shift(ps * bb, 24) + round_shift(ts * c01, 16)
         + round_shift(tp * d, 24);
    p  = clamp_to(round_shift(p8, 2), -64'sd2147483648, 64'sd2147483647);
    r.pressure    = p[31:0];
    r.temperature = t[23:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin
    int phase;
    m_tready = 1'b0;
    phase    = 0;
    @(negedge clk);
    while (1) begin
      if (hold_off_req) begin
        // Hold off long enough for the pipeline and queue to fill up.
        m_tready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_off_req = 1'b0;
      end
      phase = (phase + 1) % 64;
      if (!rx_enable) begin
        m_tready <= 1'b0;
      end else if (phase < 24) begin
        m_tready <= 1'b1;           // stretch with no stall
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
      @(negedge clk);
    end
  end

  // Check each accepted result against the oldest expected reading.
  always @(posedge clk) begin
    reading_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      results_seen++;
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected result p=%0d t=%0d", $time, got.pressure,
                 got.temperature);
        errors++;
      end else begin
        want = readings_due.pop_front();
        if (got.pressure !== want.pressure) begin
          $display("%0t: pressure mismatch expected %0d actual %0d", $time,
                   want.pressure, got.pressure);
          errors++;
        end
        if (got.temperature !== want.temperature) begin
          $display("%0t: temperature mismatch expected %0d actual %0d", $time,
                   want.temperature, got.temperature);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  int burst_left;

  // Offer one item; predict at the accepting edge. Gaps come between bursts.
  task automatic send_sample(input logic [23:0] raw_t, input logic [23:0] raw_p);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {raw_p, raw_t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    readings_due.push_back(compensate(raw_t, raw_p));
    items_sent++;
    @(negedge clk);
    if (burst_left == 0) s_tvalid <= 1'b0;
  endtask

  // Drop valid and wait until every expected reading has come back.
  task automatic drain_results();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (readings_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_CALIB_LOW:  calib_low  = value;
      CFG_CALIB_MID:  calib_mid  = value;
      CFG_CALIB_HIGH: calib_high = value;
      CFG_TEMP_OS:    temp_os    = value[2:0];
      CFG_PRESS_OS:   press_os   = value[2:0];
      default: ;
    endcase
  endtask

  task automatic load_setup(input logic [47:0] lo, input logic [47:0] mid,
                            input logic [47:0] hi, input logic [2:0] t_os,
                            input logic [2:0] p_os);
    write_reg(CFG_CALIB_LOW, lo);
    write_reg(CFG_CALIB_MID, mid);
    write_reg(CFG_CALIB_HIGH, hi);
    write_reg(CFG_TEMP_OS, {45'h0, t_os});
    write_reg(CFG_PRESS_OS, {45'h0, p_os});
  endtask

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
  endfunction

  function automatic logic [23:0] rand_raw();
    case ($urandom_range(0, 5))
      0:       return 24'(24'h800000 + $urandom_range(0, 3));
      1:       return 24'(24'h7FFFFF - $urandom_range(0, 3));
      2:       return 24'($urandom_range(0, 15) - 8);
      default: return 24'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: zero calibration, default oversampling codes.
  task automatic test_reset_defaults();
    send_sample(24'h000000, 24'h000000);
    send_sample(24'h7FFFFF, 24'h800000);
    send_sample(24'h800000, 24'h7FFFFF);
    drain_results();
  endtask

  // Extreme raw values against every oversampling code and extreme calibration.
  task automatic test_directed_extremes();
    load_setup(48'h7FF7FF_7FFFF7, 48'hFFFF7F_FF7FFF, 48'h7FFF7F_FF7FFF, 3'd0, 3'd0);
    send_sample(24'h7FFFFF, 24'h7FFFFF);
    send_sample(24'h800000, 24'h800000);
    send_sample(24'h000001, 24'hFFFFFF);
    drain_results();
    load_setup(48'h800800_000008, 48'h000080_008000, 48'h800080_008000, 3'd7, 3'd4);
    send_sample(24'h7FFFFF, 24'h800000);
    send_sample(24'h800000, 24'h7FFFFF);
    send_sample(24'h123456, 24'hABCDEF);
    drain_results();
    for (int c = 0; c < 8; c++) begin
      load_setup(rand48(), rand48(), rand48(), c[2:0], 3'(7 - c));
      send_sample(24'h7FFFFF, 24'h800000);
      send_sample(rand_raw(), rand_raw());
      drain_results();
    end
    // All-ones calibration, so every coefficient reads as -1, with extreme raw values.
    load_setup(48'hFFFFFF_FFFFFF, 48'hFFFFFF_FFFFFF, 48'hFFFFFF_FFFFFF, 3'd4, 3'd4);
    send_sample(24'h800000, 24'h800000);
    send_sample(24'h7FFFFF, 24'h7FFFFF);
    drain_results();
    // Unknown register index is ignored.
    write_reg(3'd5, 48'hFFFF_FFFF_FFFF);
    write_reg(3'd7, 48'h0);
    send_sample(24'h400000, 24'hC00000);
    drain_results();
  endtask

  // Random samples across several random calibration sets and codes.
  task automatic test_random_stream();
    for (int set = 0; set < 12; set++) begin
      load_setup(rand48(), rand48(), rand48(), 3'($urandom_range(0, 7)),
                 3'($urandom_range(0, 7)));
      for (int i = 0; i < 100; i++) send_sample(rand_raw(), rand_raw());
      drain_results();
    end
  endtask

  // Long receiver hold-off while the sender keeps offering items.
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    for (int i = 0; i < 80; i++) send_sample(rand_raw(), rand_raw());
    drain_results();
  endtask

  initial begin
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    rst          = 1'b1;
    errors       = 0;
    items_sent   = 0;
    results_seen = 0;
    hold_off_req = 1'b0;
    rx_enable    = 1'b1;
    burst_left   = 0;
    calib_low    = '0;
    calib_mid    = '0;
    calib_high   = '0;
    temp_os      = TEMP_OS_RESET;
    press_os     = PRESS_OS_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (2) @(negedge clk);

    test_reset_defaults();
    test_directed_extremes();
    test_random_stream();
    test_backpressure();

    $display("Covered %0d samples and %0d results over all oversampling codes,",
             items_sent, results_seen);
    $display("extreme and random calibration sets, saturation and backpressure.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
